// ===== sv/arp_cache_table_with_aging_unit_macros.svh =====
// Assertion macros for the ARP cache table checker.
// Expects clk_i and rst_ni in the scope where the macros are used.
`ifndef ARP_CACHE_TABLE_WITH_AGING_UNIT_MACROS_SVH
`define ARP_CACHE_TABLE_WITH_AGING_UNIT_MACROS_SVH

// Checked only while out of reset.
`define ARPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define ARPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== sv/arpc_pkg.sv =====
// Shared types and constants for the ARP cache table.
// No dependencies.
package arpc_pkg;

  localparam int IP_W   = 32;
  localparam int MAC_W  = 48;
  localparam int AGE_W  = 16;
  localparam int EXP_W  = 7;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 64;

  localparam logic [AGE_W-1:0] AGE_MAX     = '1;
  localparam logic [EXP_W-1:0] EXP_MAX     = '1;
  localparam logic [AGE_W-1:0] TIMEOUT_RST = 16'd15;

  // Register index decoded from paddr[2].
  localparam logic REG_TIMEOUT = 1'b0;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_TICK   = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } eng_state_e;

  typedef struct packed {
    op_e              op;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } cmd_t;

  typedef struct packed {
    logic             valid;
    logic [AGE_W-1:0] age;
    logic [MAC_W-1:0] mac;
    logic [IP_W-1:0]  ip;
  } entry_t;

  typedef struct packed {
    logic             hit;
    logic [MAC_W-1:0] mac;
    logic             insert_ok;
    logic [EXP_W-1:0] expired;
  } res_t;

endpackage

// ===== sv/arp_cache_table_with_aging_unit.sv =====
// ARP cache table with per-entry aging.
// Use: requests enter on the s_axis channel; tuser carries the kind (lookup,
// insert, tick), tdata the IPv4 address and the MAC. Every request gives
// exactly one transfer on m_axis with hit, MAC, insert status and the
// number of entries a tick expired.
// Timing: an entry memory with one read and one write port is walked one
// entry per cycle. Lookups and ticks walk every entry; an insert stops at
// the first free slot, and an unused kind skips the walk. The queue
// registers each request from the s_axis transfer. Requests are handled
// one at a time; the engine takes the next one in the cycle after
// loading the result. A two-deep command queue keeps taking requests
// while one is in work.
// Reset: a clear pass writes every entry invalid; s_axis_tready stays low
// until it finishes. timeout_ticks resets to 15 and can be written or read
// over the APB port at address 0.
// Stall: the result stays in the output register until m_axis_tready; the
// scan finishes meanwhile and the queue fills, then s_axis_tready drops.
module arp_cache_table_with_aging_unit #(
  parameter int ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // ip_addr[31:0], mac_addr[79:32]
  input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // hit[0], mac_out[48:1], insert_ok[49],
                                      // expired_count[56:50], zero[63:57]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import arpc_pkg::*;

  logic [AGE_W-1:0] timeout_q;
  logic             cmd_valid, cmd_ready, res_valid, clearing, front_ready;
  cmd_t             cmd;
  res_t             res;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TIMEOUT) ? {16'b0, timeout_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RST;
    end else if (psel && penable && pwrite && (paddr[2] == REG_TIMEOUT)) begin
      timeout_q <= pwdata[AGE_W-1:0];
    end
  end

  arpc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (!clearing),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (front_ready),
    .in_type_i   (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  arpc_engine #(
    .ENTRIES (ENTRIES)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .timeout_i   (timeout_q),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .res_valid_o (res_valid),
    .res_ready_i (m_axis_tready),
    .res_o       (res),
    .clearing_o  (clearing)
  );

  assign s_axis_tready = front_ready;
  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {7'b0, res.expired, res.insert_ok, res.mac, res.hit};

endmodule

// ===== sv/arpc_front.sv =====
// Request front end: decodes the request kind and queues commands.
// Depends on arpc_pkg.
module arpc_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         in_type_i,
  input  logic [arpc_pkg::IN_TDATA_W-1:0]    in_data_i,
  output logic                               cmd_valid_o,
  input  logic                               cmd_ready_i,
  output arpc_pkg::cmd_t                     cmd_o
);
  import arpc_pkg::*;

  localparam logic [1:0] QDEPTH = 2'd2;

  cmd_t       q_mem_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  cmd_t       cmd_new;
  logic       push, pop;

  always_comb begin
    unique case (in_type_i)
      2'd0:    cmd_new.op = OP_LOOKUP;
      2'd1:    cmd_new.op = OP_INSERT;
      2'd2:    cmd_new.op = OP_TICK;
      default: cmd_new.op = OP_NOP;
    endcase
    cmd_new.ip  = in_data_i[IP_W-1:0];
    cmd_new.mac = in_data_i[IP_W+MAC_W-1:IP_W];
  end

  assign in_ready_o  = en_i && (cnt_q != QDEPTH);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem_q[rptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wptr_d = push ? ~wptr_q : wptr_q;
    rptr_d = pop ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wptr_q] <= cmd_new;
    end
  end

endmodule

// ===== sv/arpc_engine.sv =====
// Table engine: entry memory, per-entry scan for lookup, insert and tick,
// and the result register. Depends on arpc_pkg.
module arpc_engine #(
  parameter int ENTRIES = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [arpc_pkg::AGE_W-1:0]  timeout_i,
  input  logic                        cmd_valid_i,
  output logic                        cmd_ready_o,
  input  arpc_pkg::cmd_t              cmd_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output arpc_pkg::res_t              res_o,
  output logic                        clearing_o
);
  import arpc_pkg::*;

  localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNTW = $clog2(ENTRIES + 1);
  localparam logic [IDXW-1:0] LAST_IDX  = IDXW'(ENTRIES - 1);
  localparam logic [CNTW-1:0] ISS_END   = CNTW'(ENTRIES);

  eng_state_e      state_q, state_d;
  cmd_t            cmd_q, cmd_d;
  logic [CNTW-1:0] iss_q, iss_d;
  logic [IDXW-1:0] proc_q, proc_d;
  res_t            res_q, res_d;
  res_t            out_q, out_d;
  logic            ovld_q, ovld_d;

  entry_t          mem [ENTRIES];
  entry_t          rdata_q;
  logic            rd_en, we;
  logic [IDXW-1:0] rd_addr, waddr;
  entry_t          wdata;

  logic            fin, load, out_free;
  logic [AGE_W-1:0] age_inc;

  assign out_free    = !ovld_q || res_ready_i;
  assign res_valid_o = ovld_q;
  assign res_o       = out_q;
  assign clearing_o  = (state_q == ST_CLEAR);
  assign age_inc     = (rdata_q.age == AGE_MAX) ? rdata_q.age : rdata_q.age + 16'd1;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (iss_q[IDXW-1:0] == LAST_IDX) state_d = ST_IDLE;
      ST_IDLE: begin
        if (cmd_valid_i) begin
          state_d = (cmd_i.op == OP_NOP) ? ST_EMIT : ST_SCAN;
        end
      end
      ST_SCAN:  if (fin) state_d = ST_EMIT;
      ST_EMIT:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready_o = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = iss_q[IDXW-1:0];
    we          = 1'b0;
    waddr       = proc_q;
    wdata       = rdata_q;
    iss_d       = iss_q;
    proc_d      = proc_q;
    res_d       = res_q;
    cmd_d       = cmd_q;
    load        = 1'b0;
    fin         = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = iss_q[IDXW-1:0];
        wdata = '0;
        iss_d = iss_q + CNTW'(1);
      end
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cmd_d  = cmd_i;
          res_d  = '0;
          rd_en  = (cmd_i.op != OP_NOP);
          rd_addr = '0;
          iss_d  = CNTW'(1);
          proc_d = '0;
        end
      end
      ST_SCAN: begin
        if (iss_q != ISS_END) begin
          rd_en  = 1'b1;
          iss_d  = iss_q + CNTW'(1);
          proc_d = iss_q[IDXW-1:0];
        end
        unique case (cmd_q.op)
          OP_LOOKUP: begin
            if (rdata_q.valid && (rdata_q.ip == cmd_q.ip)) begin
              res_d.hit = 1'b1;
              res_d.mac = rdata_q.mac;
            end
            fin = (proc_q == LAST_IDX);
          end
          OP_INSERT: begin
            if (!rdata_q.valid) begin
              we              = 1'b1;
              wdata.valid     = 1'b1;
              wdata.age       = '0;
              wdata.mac       = cmd_q.mac;
              wdata.ip        = cmd_q.ip;
              res_d.insert_ok = 1'b1;
              fin             = 1'b1;
            end else begin
              fin = (proc_q == LAST_IDX);
            end
          end
          OP_TICK: begin
            if (rdata_q.valid) begin
              we        = 1'b1;
              wdata.age = age_inc;
              if (age_inc > timeout_i) begin
                wdata.valid = 1'b0;
                if (res_q.expired != EXP_MAX) begin
                  res_d.expired = res_q.expired + 7'd1;
                end
              end
            end
            fin = (proc_q == LAST_IDX);
          end
          default: fin = 1'b1;
        endcase
      end
      ST_EMIT: load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_d  = load ? res_q : out_q;
    ovld_d = ovld_q;
    if (load) begin
      ovld_d = 1'b1;
    end else if (res_ready_i) begin
      ovld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      iss_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      iss_q   <= iss_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    proc_q <= proc_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/arpc_checker.sv =====
// Port-level checks for the ARP cache table, bound to the top level.
// Depends on arp_cache_table_with_aging_unit_macros.svh.
`include "arp_cache_table_with_aging_unit_macros.svh"

module arpc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  logic        stall;
  logic        hit;
  logic        ins_ok;
  logic [47:0] mac;
  logic [13:0] upper;
  logic        mixed;

  assign stall  = m_axis_tvalid && !m_axis_tready;
  assign hit    = m_axis_tdata[0];
  assign mac    = m_axis_tdata[48:1];
  assign ins_ok = m_axis_tdata[49];
  assign upper  = m_axis_tdata[63:50];
  assign mixed  = (upper != 14'd0) || (hit && ins_ok);

  `ARPC_ASSERT(a_out_hold, stall |=> m_axis_tvalid, "result dropped")
  `ARPC_ASSERT(a_out_stable, stall |=> $stable(m_axis_tdata), "result changed while stalled")
  `ARPC_ASSERT(a_miss_mac, m_axis_tvalid && !hit |-> mac == 48'd0, "MAC nonzero on miss")
  `ARPC_ASSERT(a_one_kind, m_axis_tvalid && (hit || ins_ok) |-> !mixed, "mixed result kinds")
  `ARPC_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !m_axis_tvalid, "result during reset")

endmodule

bind arp_cache_table_with_aging_unit arpc_checker u_arpc_checker (.*);

// ===== sim/tb.sv =====
// Testbench for arp_cache_table_with_aging_unit: lookups, inserts and ticks are
// predicted by an in-bench model of the table and compared with every m_axis transfer.
// Depends on arpc_pkg and the unit itself.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import arpc_pkg::*;

  localparam int ENTRIES = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [2:0] TIMEOUT_ADDR = 3'd0;
  localparam logic [2:0] SPARE_ADDR = 3'd4;
  localparam int POOL_N = 16;

  typedef struct packed {
    logic [6:0]       pad;
    logic [EXP_W-1:0] expired;
    logic             insert_ok;
    logic [MAC_W-1:0] mac;
    logic             hit;
  } arp_reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;   // ip_addr[31:0], mac_addr[79:32]
  logic [1:0]  s_axis_tuser = '0;   // req_type[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // hit[0], mac_out[48:1], insert_ok[49],
                                    // expired_count[56:50], zero[63:57]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  arp_cache_table_with_aging_unit #(.ENTRIES(ENTRIES)) i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #1 clk_i = ~clk_i;

  // table image
  logic             tbl_valid[ENTRIES];
  logic [IP_W-1:0]  tbl_ip[ENTRIES];
  logic [MAC_W-1:0] tbl_mac[ENTRIES];
  logic [AGE_W-1:0] tbl_age[ENTRIES];
  logic [AGE_W-1:0] timeout_now = TIMEOUT_RST;

  arp_reply_t       pending_replies[$];
  logic [IP_W-1:0]  ip_pool[POOL_N];
  int               mismatches = 0;
  int               cycles = 0;
  int               burst_left = 0;
  int               rx_mode = 0;
  int               rx_mode_left = 0;
  int               rx_hold = 0;

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
    end
  end

  function automatic arp_reply_t arp_predict(op_e op, logic [IP_W-1:0] ip,
                                             logic [MAC_W-1:0] mac);
    arp_reply_t r;
    logic       placed;
    int         cnt;
    r = '0;
    placed = 1'b0;
    cnt = 0;
    case (op)
      OP_LOOKUP: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (tbl_valid[i] && tbl_ip[i] == ip) begin
            r.hit = 1'b1;
            r.mac = tbl_mac[i];
          end
        end
      end
      OP_INSERT: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (!placed && !tbl_valid[i]) begin
            tbl_ip[i] = ip;
            tbl_mac[i] = mac;
            tbl_age[i] = '0;
            tbl_valid[i] = 1'b1;
            placed = 1'b1;
          end
        end
        r.insert_ok = placed;
      end
      OP_TICK: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (tbl_valid[i]) begin
            if (tbl_age[i] != AGE_MAX) tbl_age[i] = tbl_age[i] + 1'b1;
            if (tbl_age[i] > timeout_now) begin
              tbl_valid[i] = 1'b0;
              if (cnt < EXP_MAX) cnt++;
            end
          end
        end
        r.expired = EXP_W'(cnt);
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch %s: expected %h, got %h", what, want, got);
  endtask

  // one request on s_axis, bursts with random gaps in between
  task automatic send_req(input op_e op, input logic [IP_W-1:0] ip,
                          input logic [MAC_W-1:0] mac);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {mac, ip};
    s_axis_tuser <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_replies.push_back(arp_predict(op, ip, mac));
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == TIMEOUT_ADDR) timeout_now = data[AGE_W-1:0];
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_timeout_readback();
    logic [31:0] got;
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= TIMEOUT_ADDR;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    if (got != {16'b0, timeout_now}) flag_mismatch("timeout_ticks readback",
                                                    {48'b0, timeout_now}, {32'b0, got});
  endtask

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [MAC_W-1:0] m;
    m[31:0] = $urandom;
    m[47:32] = 16'($urandom_range(0, 16'hFFFF));
    return m;
  endfunction

  // reset value, spare address ignored, upper write bits dropped
  task automatic test_register_access();
    check_timeout_readback();
    apb_write(SPARE_ADDR, $urandom);
    check_timeout_readback();
    apb_write(TIMEOUT_ADDR, 32'hFFFF_0003);
    check_timeout_readback();
    apb_write(TIMEOUT_ADDR, 32'd15);
  endtask

  task automatic test_basic_ops();
    send_req(OP_LOOKUP, 32'h0, 48'h0);
    send_req(OP_LOOKUP, 32'hFFFF_FFFF, '1);
    send_req(OP_NOP, 32'hFFFF_FFFF, '1);
    send_req(OP_NOP, $urandom, rand_mac());
    send_req(OP_INSERT, 32'h0, 48'h0);
    send_req(OP_INSERT, 32'hFFFF_FFFF, '1);
    send_req(OP_INSERT, 32'h0, 48'h0123_4567_89AB);
    send_req(OP_LOOKUP, 32'h0, 48'h0);
    send_req(OP_LOOKUP, 32'hFFFF_FFFF, 48'h0);
    send_req(OP_LOOKUP, 32'h0A00_0001, 48'h0);
    send_req(OP_TICK, $urandom, rand_mac());
    send_req(OP_TICK, 32'h0, 48'h0);
    send_req(OP_LOOKUP, 32'h0, '1);
  endtask

  task automatic test_timeout_extremes();
    logic [IP_W-1:0] ip_a;
    ip_a = $urandom;
    wait_idle();
    apb_write(TIMEOUT_ADDR, 32'd0);
    send_req(OP_INSERT, ip_a, rand_mac());
    send_req(OP_TICK, 32'h0, 48'h0);
    send_req(OP_LOOKUP, ip_a, 48'h0);
    send_req(OP_INSERT, ip_a, rand_mac());
    wait_idle();
    apb_write(TIMEOUT_ADDR, 32'd65534);
    check_timeout_readback();
    send_req(OP_TICK, 32'h0, 48'h0);
    send_req(OP_TICK, 32'h0, 48'h0);
    send_req(OP_LOOKUP, ip_a, 48'h0);
    wait_idle();
    apb_write(TIMEOUT_ADDR, 32'd1);
    send_req(OP_TICK, 32'h0, 48'h0);
    send_req(OP_LOOKUP, ip_a, 48'h0);
  endtask

  // fill every slot, overflow it, then expire all at once
  task automatic test_table_full();
    int free_slots;
    wait_idle();
    apb_write(TIMEOUT_ADDR, 32'd65534);
    free_slots = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!tbl_valid[i]) free_slots++;
    end
    repeat (free_slots + 4) send_req(OP_INSERT, $urandom, rand_mac());
    send_req(OP_LOOKUP, tbl_ip[ENTRIES-1], 48'h0);
    send_req(OP_TICK, 32'h0, 48'h0);
    wait_idle();
    apb_write(TIMEOUT_ADDR, 32'd0);
    send_req(OP_TICK, 32'h0, 48'h0);
    send_req(OP_LOOKUP, tbl_ip[0], 48'h0);
  endtask

  task automatic test_random_mix();
    logic [31:0] timeouts[8];
    int          pick;
    op_e         op;
    logic [IP_W-1:0] ip;
    timeouts = '{32'd1, 32'd2, 32'd3, 32'd7, 32'd15, 32'd40, 32'd65534, 32'd0};
    timeouts[7] = $urandom_range(0, 65534);
    foreach (timeouts[t]) begin
      wait_idle();
      apb_write(TIMEOUT_ADDR, timeouts[t]);
      check_timeout_readback();
      for (int i = 0; i < POOL_N; i++) ip_pool[i] = $urandom;
      repeat (55) begin
        pick = $urandom_range(0, 99);
        if (pick < 38) op = OP_INSERT;
        else if (pick < 73) op = OP_LOOKUP;
        else if (pick < 95) op = OP_TICK;
        else op = OP_NOP;
        ip = ($urandom_range(0, 4) != 0) ? ip_pool[$urandom_range(0, POOL_N-1)] : $urandom;
        send_req(op, ip, rand_mac());
      end
    end
  endtask

  // receiver: always ready, random, or long stalls
  always @(negedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_mode_left = $urandom_range(50, 300);
    end else begin
      rx_mode_left--;
    end
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      default: begin
        if (rx_hold > 0) begin
          rx_hold--;
        end else begin
          m_axis_tready <= !m_axis_tready;
          rx_hold = m_axis_tready ? $urandom_range(8, 40) : $urandom_range(0, 3);
        end
      end
    endcase
  end

  always @(posedge clk_i) begin
    arp_reply_t want;
    arp_reply_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_replies.size() == 0) begin
        flag_mismatch("transfer with nothing pending", 64'h0, m_axis_tdata);
      end else begin
        want = pending_replies.pop_front();
        if (got.hit != want.hit) flag_mismatch("hit", 64'(want.hit), 64'(got.hit));
        if (got.mac != want.mac) flag_mismatch("mac_out", 64'(want.mac), 64'(got.mac));
        if (got.insert_ok != want.insert_ok)
          flag_mismatch("insert_ok", 64'(want.insert_ok), 64'(got.insert_ok));
        if (got.expired != want.expired)
          flag_mismatch("expired_count", 64'(want.expired), 64'(got.expired));
        if (got.pad != '0) flag_mismatch("tdata padding", 64'h0, 64'(got.pad));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_register_access();
    test_basic_ops();
    test_timeout_extremes();
    test_table_full();
    test_random_mix();
    wait_idle();
    repeat (ENTRIES + 8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
